// ===== hw/rtl/lzbp_pkg.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer package
// Shared constants and types for the token bit packer.
// ---------------------------------------------------------------------------
`default_nettype none

package lzbp_pkg;

  // Default field widths of the raw match fields
  localparam int OFFSET_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF = 8;

  // Fixed port field widths
  localparam int KIND_W      = 2;
  localparam int HUFF_CODE_W = 32;
  localparam int HUFF_LEN_W  = 6;
  localparam int MOFF_W      = 16;
  localparam int MLEN_W      = 8;
  localparam int IN_DATA_W   = 64;
  localparam int BYTE_W      = 8;
  localparam int FVB_W       = 4;

  // Longest Huffman code and the carried partial byte
  localparam int HUFF_MAX    = 32;
  localparam int PARTIAL_W   = 7;

  // Depth of the queue between the front and back parts (power of two)
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    TK_LITERAL = 2'd0,
    TK_MATCH   = 2'd1,
    TK_END     = 2'd2
  } token_kind_e;

endpackage

`default_nettype wire

// ===== hw/rtl/lzbp_front.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer front part
// Accepts tokens, appends their bits to the carried partial byte and works
// out how many bytes the back part has to send for each token.
// ---------------------------------------------------------------------------
`default_nettype none

module lzbp_front #(
  parameter int OFFSET_BITS = lzbp_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = lzbp_pkg::LENGTH_BITS_DEF,
  parameter int ACC_W       = 48,
  parameter int CNT_W       = 6,
  parameter int NB_W        = 4,
  parameter int ENTRY_W     = 63
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [lzbp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [lzbp_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output logic [ENTRY_W-1:0]                 push_data_o
);

  localparam int MatchN = 1 + OFFSET_BITS + LENGTH_BITS;
  localparam int PW     = lzbp_pkg::PARTIAL_W;

  logic [lzbp_pkg::HUFF_CODE_W-1:0] huff_code;
  logic [lzbp_pkg::HUFF_LEN_W-1:0]  huff_len;
  logic [lzbp_pkg::MOFF_W-1:0]      match_offset;
  logic [lzbp_pkg::MLEN_W-1:0]      match_length;
  logic [OFFSET_BITS-1:0]           off_v;
  logic [LENGTH_BITS-1:0]           len_v;
  logic [lzbp_pkg::HUFF_LEN_W-1:0]  hlen_c;

  logic [PW-1:0]    partial_q, partial_d;
  logic [2:0]       pcount_q, pcount_d;

  logic             known;
  logic             is_end;
  logic [CNT_W-1:0] n_bits;
  logic [ACC_W-1:0] payload;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       rem;
  logic [NB_W-1:0]  nb;
  logic [lzbp_pkg::FVB_W-1:0] fvb;
  logic             accept;

  assign huff_code    = s_axis_tdata[31:0];
  assign huff_len     = s_axis_tdata[37:32];
  assign match_offset = s_axis_tdata[53:38];
  assign match_length = s_axis_tdata[61:54];
  assign off_v        = OFFSET_BITS'(match_offset);
  assign len_v        = LENGTH_BITS'(match_length);
  assign hlen_c       = (huff_len > lzbp_pkg::HUFF_LEN_W'(lzbp_pkg::HUFF_MAX))
                        ? lzbp_pkg::HUFF_LEN_W'(lzbp_pkg::HUFF_MAX) : huff_len;

  always_comb begin
    known   = 1'b1;
    is_end  = 1'b0;
    n_bits  = '0;
    payload = '0;
    unique case (lzbp_pkg::token_kind_e'(s_axis_tuser))
      lzbp_pkg::TK_MATCH: begin
        n_bits  = CNT_W'(MatchN);
        payload = ACC_W'({1'b1, off_v, len_v});
      end
      lzbp_pkg::TK_LITERAL, lzbp_pkg::TK_END: begin
        is_end  = (lzbp_pkg::token_kind_e'(s_axis_tuser) == lzbp_pkg::TK_END);
        n_bits  = CNT_W'(hlen_c) + CNT_W'(1);
        // The flag bit is zero, so only the masked code remains.
        payload = ACC_W'(huff_code) & ~({ACC_W{1'b1}} << hlen_c);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign acc = (ACC_W'(partial_q) << n_bits) | payload;
  assign cnt = CNT_W'(pcount_q) + n_bits;
  assign rem = cnt[2:0];

  always_comb begin
    nb = NB_W'(cnt[CNT_W-1:3]);
    if (is_end && (rem != 3'd0)) begin
      nb = nb + NB_W'(1);
    end
    fvb = (rem == 3'd0) ? lzbp_pkg::FVB_W'(8) : lzbp_pkg::FVB_W'(rem);
  end

  // A token that completes no byte only updates the carried bits.
  assign s_axis_tready = push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready && known;
  assign push_valid_o  = s_axis_tvalid && known && (nb != '0);
  assign push_data_o   = {is_end, fvb, nb, cnt, acc};

  always_comb begin
    partial_d = partial_q;
    pcount_d  = pcount_q;
    if (accept) begin
      if (is_end) begin
        partial_d = '0;
        pcount_d  = '0;
      end else begin
        partial_d = acc[PW-1:0] & ~({PW{1'b1}} << rem);
        pcount_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pcount_q  <= '0;
    end else begin
      partial_q <= partial_d;
      pcount_q  <= pcount_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzbp_queue.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer queue
// Short first-in first-out queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module lzbp_queue #(
  parameter int WIDTH = 63,
  parameter int DEPTH = lzbp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzbp_back.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer back part
// Takes queued bit strings, left aligns them and sends one byte per cycle
// through an output register while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module lzbp_back #(
  parameter int ACC_W   = 48,
  parameter int CNT_W   = 6,
  parameter int NB_W    = 4,
  parameter int ENTRY_W = 63
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pop_valid_i,
  output logic                             pop_ready_o,
  input  wire logic [ENTRY_W-1:0]          pop_data_i,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [lzbp_pkg::BYTE_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic [lzbp_pkg::FVB_W-1:0]       m_axis_tuser
);

  localparam int BW = lzbp_pkg::BYTE_W;
  localparam int FW = lzbp_pkg::FVB_W;

  logic             e_end;
  logic [FW-1:0]    e_fvb;
  logic [NB_W-1:0]  e_nb;
  logic [CNT_W-1:0] e_cnt;
  logic [ACC_W-1:0] e_acc;

  logic             cur_valid_q, cur_valid_d;
  logic [ACC_W-1:0] sh_q, sh_d;
  logic [NB_W-1:0]  rem_q, rem_d;
  logic             end_q, end_d;
  logic [FW-1:0]    fvb_q, fvb_d;

  logic             out_valid_q, out_valid_d;
  logic [BW-1:0]    out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic [FW-1:0]    out_fvb_q, out_fvb_d;

  logic             out_free, issue, issue_last, load;

  assign {e_end, e_fvb, e_nb, e_cnt, e_acc} = pop_data_i;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign issue       = cur_valid_q && out_free;
  assign issue_last  = issue && (rem_q == NB_W'(1));
  assign pop_ready_o = !cur_valid_q || issue_last;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    cur_valid_d = cur_valid_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    end_d       = end_q;
    fvb_d       = fvb_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_fvb_d   = out_fvb_q;

    if (issue) begin
      out_valid_d = 1'b1;
      out_byte_d  = sh_q[ACC_W-1 -: BW];
      out_last_d  = issue_last;
      out_fvb_d   = (issue_last && end_q) ? fvb_q : '0;
      sh_d        = sh_q << BW;
      rem_d       = rem_q - NB_W'(1);
      if (issue_last) begin
        cur_valid_d = 1'b0;
      end
    end

    // The oldest bit goes to the top; the zeros shifted in pad the last byte.
    if (load) begin
      cur_valid_d = 1'b1;
      sh_d        = e_acc << (CNT_W'(ACC_W) - e_cnt);
      rem_d       = e_nb;
      end_d       = e_end;
      fvb_d       = e_fvb;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    rem_q      <= rem_d;
    end_q      <= end_d;
    fvb_q      <= fvb_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_fvb_q  <= out_fvb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fvb_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_token_bit_packer_unit.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer
// Packs literal, match and end tokens MSB first into a byte stream.
// ---------------------------------------------------------------------------
//  Channel  Dir  Contents
//  s_axis   in   tuser: token_kind[1:0]
//                tdata: huff_code[31:0], huff_len[37:32],
//                       match_offset[53:38], match_length[61:54]
//  m_axis   out  tdata: out_byte[7:0], tlast: last_of_run,
//                tuser: final_valid_bits[3:0]
//
//  A token that completes at least one byte is queued as one entry of its
//  bits; the back part then sends one byte per cycle while the output is not
//  stalled. A token completes 0 to 5 bytes with default widths. Tokens keep
//  flowing while the four-entry queue has room.
//  Reset clears the carried partial byte, the queue and the output register.
//  A stalled output holds its byte; the front keeps accepting until the
//  queue fills.
// ---------------------------------------------------------------------------
`default_nettype none

module lzss_token_bit_packer_unit #(
  parameter int OFFSET_BITS = lzbp_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = lzbp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // huff_code, huff_len, match_offset, match_length (lowest bits first)
  input  wire logic [lzbp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // token_kind
  input  wire logic [lzbp_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_byte
  output logic [lzbp_pkg::BYTE_W-1:0]         m_axis_tdata,
  output logic                                m_axis_tlast,
  // final_valid_bits
  output logic [lzbp_pkg::FVB_W-1:0]          m_axis_tuser
);

  localparam int LitN    = 1 + lzbp_pkg::HUFF_MAX;
  localparam int MatchN  = 1 + OFFSET_BITS + LENGTH_BITS;
  localparam int PayMax  = (LitN > MatchN) ? LitN : MatchN;
  localparam int AccW    = lzbp_pkg::PARTIAL_W + PayMax;
  localparam int CntW    = $clog2(AccW + 1);
  localparam int NbW     = $clog2(AccW / lzbp_pkg::BYTE_W + 2);
  localparam int EntryW  = 1 + lzbp_pkg::FVB_W + NbW + CntW + AccW;

  logic              push_valid, push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  lzbp_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .ACC_W       (AccW),
    .CNT_W       (CntW),
    .NB_W        (NbW),
    .ENTRY_W     (EntryW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  lzbp_queue #(
    .WIDTH (EntryW),
    .DEPTH (lzbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lzbp_back #(
    .ACC_W   (AccW),
    .CNT_W   (CntW),
    .NB_W    (NbW),
    .ENTRY_W (EntryW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lzbp_checker.sv =====
// ---------------------------------------------------------------------------
// LZSS token bit packer checker
// Port level checks on the packed byte stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lzbp_props (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [lzbp_pkg::BYTE_W-1:0]    m_axis_tdata,
  input wire logic                           m_axis_tlast,
  input wire logic [lzbp_pkg::FVB_W-1:0]     m_axis_tuser
);

  // A valid-bit count only appears on the final byte of a token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != '0) |-> m_axis_tlast)
    else $error("valid-bit count on a byte that is not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= lzbp_pkg::FVB_W'(8)))
    else $error("valid-bit count above eight");

  // Padding below the valid bits of a flushed byte must be zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != '0)
      |-> ((m_axis_tdata & (8'hFF >> m_axis_tuser)) == 8'h00))
    else $error("flushed byte carries non-zero padding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
          && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

endmodule

bind lzss_token_bit_packer_unit lzbp_props u_lzbp_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/lzbp_checker.sv =====
// ---------------------------------------------------------------------------
// Token bit packer checker
// Watches both stream channels of the packer. Every accepted token is packed
// into expected bytes by a local model of the bit accumulator, and every
// accepted output item is compared with the oldest expected byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzbp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // huff_code, huff_len, match_offset, match_length (lowest bits first)
  input  logic [lzbp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // token_kind
  input  logic [lzbp_pkg::KIND_W-1:0]    s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_byte
  input  logic [lzbp_pkg::BYTE_W-1:0]    m_axis_tdata,
  input  logic                           m_axis_tlast,
  // final_valid_bits
  input  logic [lzbp_pkg::FVB_W-1:0]     m_axis_tuser,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic [lzbp_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [lzbp_pkg::FVB_W-1:0]  valid_bits;
  } packed_byte_t;

  packed_byte_t                   byte_q[$];
  logic [lzbp_pkg::PARTIAL_W-1:0] carry_bits;
  int unsigned                    carry_cnt;
  int                             fail_count;

  assign fail_count_o = fail_count;

  function automatic logic [63:0] low_ones(input int unsigned n);
    return (64'd1 << n) - 64'd1;
  endfunction

  // Appends the bytes that one token completes, and updates the carried bits.
  function automatic void pack_token(input logic [lzbp_pkg::KIND_W-1:0] kind,
                                     input logic [lzbp_pkg::IN_DATA_W-1:0] data);
    logic [lzbp_pkg::HUFF_CODE_W-1:0] code;
    int unsigned                      code_len;
    logic [lzbp_pkg::MOFF_W-1:0]      moff;
    logic [lzbp_pkg::MLEN_W-1:0]      mlen;
    logic [63:0]                      acc;
    logic [63:0]                      shifted;
    int unsigned                      cnt;
    int unsigned                      valid;
    packed_byte_t                     run_q[$];
    packed_byte_t                     item;

    code     = data[31:0];
    code_len = data[37:32];
    moff     = data[53:38];
    mlen     = data[61:54];
    if (code_len > lzbp_pkg::HUFF_MAX) code_len = lzbp_pkg::HUFF_MAX;

    acc = 64'(carry_bits);
    cnt = carry_cnt;

    case (kind)
      lzbp_pkg::TK_MATCH: begin
        acc = (acc << 1) | 64'd1;
        acc = (acc << lzbp_pkg::OFFSET_BITS_DEF)
              | (64'(moff) & low_ones(lzbp_pkg::OFFSET_BITS_DEF));
        acc = (acc << lzbp_pkg::LENGTH_BITS_DEF)
              | (64'(mlen) & low_ones(lzbp_pkg::LENGTH_BITS_DEF));
        cnt += 1 + lzbp_pkg::OFFSET_BITS_DEF + lzbp_pkg::LENGTH_BITS_DEF;
      end
      lzbp_pkg::TK_LITERAL, lzbp_pkg::TK_END: begin
        acc = acc << 1;
        cnt += 1;
        if (code_len > 0) begin
          acc = (acc << code_len) | (64'(code) & low_ones(code_len));
          cnt += code_len;
        end
      end
      default: begin
        // The fourth kind is dropped by the block without any effect.
        return;
      end
    endcase

    while (cnt >= 8) begin
      cnt -= 8;
      shifted         = acc >> cnt;
      item.data       = shifted[7:0];
      item.last       = 1'b0;
      item.valid_bits = '0;
      run_q           = {run_q, item};
    end
    acc &= low_ones(cnt);

    if (kind == lzbp_pkg::TK_END) begin
      valid = 8;
      if (cnt > 0) begin
        valid           = cnt;
        shifted         = acc << (8 - cnt);
        item.data       = shifted[7:0];
        item.last       = 1'b0;
        item.valid_bits = '0;
        run_q           = {run_q, item};
        cnt = 0;
        acc = '0;
      end
      run_q[run_q.size()-1].valid_bits = lzbp_pkg::FVB_W'(valid);
    end

    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;

    byte_q     = {byte_q, run_q};
    carry_bits = acc[lzbp_pkg::PARTIAL_W-1:0];
    carry_cnt  = cnt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    if (!rst_ni) begin
      byte_q.delete();
      carry_bits = '0;
      carry_cnt  = 0;
      fail_count = 0;
      pending_o <= 0;
    end else begin
      // Output items belong to earlier tokens, so they are checked first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (byte_q.size() == 0) begin
          $error("unexpected output item: out_byte 0x%02h", m_axis_tdata);
          fail_count++;
        end else begin
          want = byte_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser !== want.valid_bits) begin
            $error("final_valid_bits: expected %0d, got %0d", want.valid_bits,
                   m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pack_token(s_axis_tuser, s_axis_tdata);
      pending_o <= byte_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Token bit packer testbench
// Drives literal, match, end and unknown tokens into the packer, first a
// directed set of edge cases and then random streams, with random gaps on the
// input and random back-pressure on the output. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 350;
  localparam int PHASES       = 5;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_LIMIT   = 1000;

  // Token kind that the block ignores.
  localparam logic [lzbp_pkg::KIND_W-1:0] TK_UNKNOWN = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [lzbp_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [lzbp_pkg::KIND_W-1:0]    s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [lzbp_pkg::BYTE_W-1:0]    m_axis_tdata;
  logic                           m_axis_tlast;
  logic [lzbp_pkg::FVB_W-1:0]     m_axis_tuser;

  int   fail_count;
  int   pending;
  logic steady;          // no gaps and no stalls while set
  int   ready_left = 0;
  int   ready_pick;
  int   quiet_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lzss_token_bit_packer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lzbp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Output back-pressure: bursts of readiness broken by short and rare long stalls.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (steady) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(1, 16) - 1;
      end else if (ready_pick < 60) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(1, 8) - 1;
      end else if (ready_pick < 95) begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(1, 3) - 1;
      end else begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(20, 60) - 1;
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int input_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_token(input logic [lzbp_pkg::KIND_W-1:0] kind,
                            input logic [31:0] code,
                            input logic [5:0] code_len, input logic [15:0] moff,
                            input logic [7:0] mlen);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, mlen, moff, code_len, code};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly realistic short codes, with full-width and overlong lengths mixed in.
  task automatic send_random_token();
    int          pick;
    logic [5:0]  code_len;
    pick = $urandom_range(0, 99);
    if (pick < 80) code_len = 6'($urandom_range(1, 16));
    else if (pick < 90) code_len = 6'($urandom_range(0, lzbp_pkg::HUFF_MAX));
    else code_len = 6'($urandom_range(lzbp_pkg::HUFF_MAX + 1, 63));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_token(lzbp_pkg::TK_LITERAL, $urandom, code_len, 16'($urandom),
                 8'($urandom));
    end else if (pick < 80) begin
      send_token(lzbp_pkg::TK_MATCH, $urandom, code_len, 16'($urandom),
                 8'($urandom));
    end else if (pick < 93) begin
      send_token(lzbp_pkg::TK_END, $urandom, code_len, 16'($urandom),
                 8'($urandom));
    end else begin
      send_token(TK_UNKNOWN, $urandom, code_len, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain_output();
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= lzbp_pkg::TK_LITERAL;
    steady        <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, ignored fields, overlong codes, the
    // unknown kind, and flushes both on and off a byte boundary.
    send_token(lzbp_pkg::TK_LITERAL, 32'h0000_0000, 6'd0,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_END,     32'h0000_0000, 6'd0,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_END,     32'h0000_007F, 6'd7,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_END,     32'h0000_0000, 6'd0,  16'hFFFF, 8'hFF);
    send_token(lzbp_pkg::TK_LITERAL, 32'hFFFF_FFFF, 6'd32, 16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_LITERAL, 32'h0000_0000, 6'd32, 16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_MATCH,   32'h0000_0000, 6'd0,  16'hFFFF, 8'hFF);
    send_token(lzbp_pkg::TK_MATCH,   32'h0000_0000, 6'd0,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_LITERAL, 32'h1234_5678, 6'd40, 16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_LITERAL, 32'hAAAA_5555, 6'd63, 16'h0000, 8'h00);
    send_token(TK_UNKNOWN,           32'hDEAD_BEEF, 6'd21, 16'h5A5A, 8'hA5);
    send_token(lzbp_pkg::TK_MATCH,   32'hFFFF_FFFF, 6'd63, 16'h1234, 8'h56);
    send_token(lzbp_pkg::TK_LITERAL, 32'h0000_0005, 6'd3,  16'hFFFF, 8'hFF);
    send_token(lzbp_pkg::TK_LITERAL, 32'h0000_0001, 6'd1,  16'h0000, 8'h00);
    send_token(TK_UNKNOWN,           32'hFFFF_FFFF, 6'd63, 16'hFFFF, 8'hFF);
    send_token(lzbp_pkg::TK_END,     32'hFFFF_FFFF, 6'd32, 16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_END,     32'h0000_0000, 6'd7,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_MATCH,   32'h0000_0000, 6'd0,  16'h8000, 8'h80);
    send_token(lzbp_pkg::TK_LITERAL, 32'h0000_0003, 6'd6,  16'h0000, 8'h00);
    send_token(lzbp_pkg::TK_END,     32'h0000_002A, 6'd33, 16'h0000, 8'h00);

    // Hold the input back until the output has caught up completely.
    s_axis_tvalid <= 1'b0;
    drain_output();

    for (int phase = 0; phase < PHASES; phase++) begin
      steady <= (phase % 2 == 1);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_random_token();
      end
      if (phase == 2) begin
        s_axis_tvalid <= 1'b0;
        drain_output();
      end
    end
    // Close the stream so that the carried bits come out.
    send_token(lzbp_pkg::TK_END, $urandom, 6'($urandom_range(0, 8)), 16'h0000, 8'h00);
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
